// ===== sv/bounded_sequence_store_sort_find_core_macros.svh =====
// Assertion macros used by the checker file of the sequence store.
`ifndef BOUNDED_SEQUENCE_STORE_SORT_FIND_CORE_MACROS_SVH
`define BOUNDED_SEQUENCE_STORE_SORT_FIND_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSSF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bssf_pkg.sv =====
// Types and codes shared by the sequence store modules.
package bssf_pkg;

   localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [3:0] OP_POP_FRONT  = 4'd2;
   localparam logic [3:0] OP_POP_BACK   = 4'd3;
   localparam logic [3:0] OP_INSERT     = 4'd4;
   localparam logic [3:0] OP_REMOVE     = 4'd5;
   localparam logic [3:0] OP_FIND       = 4'd6;
   localparam logic [3:0] OP_SORT       = 4'd7;
   localparam logic [3:0] OP_READ       = 4'd8;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN,
      ST_FIND,
      ST_SORT_LOAD,
      ST_SORT_HOLD,
      ST_SORT_SCAN,
      ST_READ,
      ST_READ_TAKE,
      ST_ENDS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [6:0]         element_count;
      logic               is_empty;
      logic               found;
      logic [6:0]         found_position;
      logic signed [31:0] read_value;
      logic [1:0]         status;
   } rsp_payload_type;

endpackage

// ===== sv/bssf_chan_if.sv =====
// Valid/ready channel interface carrying one payload item.
interface bssf_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/bssf_mem.sv =====
// Element memory: one write port, two registered read ports.
module bssf_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

// ===== sv/bssf_seq.sv =====
// Sequencer: walks the element memory one entry per cycle.
module bssf_seq import bssf_pkg::*; #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  req_payload_type             req_payload,
   output logic                        res_valid,
   input  logic                        res_ready,
   output rsp_payload_type             res_payload,
   output logic                        mem_we,
   output logic [$clog2(CAPACITY)-1:0] mem_waddr,
   output logic [VALUE_WIDTH-1:0]      mem_wdata,
   output logic [$clog2(CAPACITY)-1:0] mem_raddr_a,
   output logic [$clog2(CAPACITY)-1:0] mem_raddr_b,
   input  logic [VALUE_WIDTH-1:0]      mem_rdata_a,
   input  logic [VALUE_WIDTH-1:0]      mem_rdata_b
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > 7) ? CW : 7;
   localparam int VW = VALUE_WIDTH;

   // low VW bits of the item; zero-extended when the store is wider than 32
   function automatic logic [VW-1:0] take_in(input logic [31:0] v);
      logic [VW+31:0] w;
      w = {{VW{1'b0}}, v};
      return w[VW-1:0];
   endfunction

   function automatic logic [31:0] give_out(input logic [VW-1:0] e);
      logic [VW+31:0] w;
      w = {{32{e[VW-1]}}, e};
      return w[31:0];
   endfunction

   function automatic logic [6:0] to7(input logic [LW-1:0] v);
      return v[6:0];
   endfunction

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pend_ff, pend_in;
   logic [VW-1:0] val_ff, val_in;
   logic [VW-1:0] cur_ff, cur_in;
   logic [AW-1:0] ipos_ff, ipos_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic [AW-1:0] i_ff, i_in;
   logic [CW-1:0] rem_ff, rem_in;
   status_type    status_ff, status_in;
   logic          found_ff, found_in;
   logic [6:0]    fpos_ff, fpos_in;
   logic [31:0]   rval_ff, rval_in;

   // request decode
   state_type     start_state;
   status_type    start_status;
   logic [AW-1:0] start_ipos, start_idx;
   logic [CW-1:0] start_rem;
   logic [LW-1:0] cnt_l, pos_l, up_l, dn_l;
   logic          full, empty, go_up, go_down;

   logic issue, hit, swap, sort_more;

   assign issue     = rem_ff != '0;
   assign hit       = mem_rdata_a == val_ff;
   assign swap      = $signed(cur_ff) > $signed(mem_rdata_a);
   assign sort_more = (CW'(i_ff) + CW'(1)) < count_ff;
   assign full      = count_ff == CW'(CAPACITY);
   assign empty     = count_ff == '0;
   assign cnt_l     = LW'(count_ff);
   assign pos_l     = LW'(req_payload.position);
   assign req_ready = state_ff == ST_IDLE;
   assign res_valid = state_ff == ST_DONE;

   always_comb begin
      up_l = pos_l;
      dn_l = pos_l;
      if (req_payload.operation == OP_PUSH_FRONT) begin
         up_l = '0;
      end else if (req_payload.operation == OP_PUSH_BACK) begin
         up_l = cnt_l;
      end
      if (req_payload.operation == OP_POP_FRONT) begin
         dn_l = '0;
      end else if (req_payload.operation == OP_POP_BACK) begin
         dn_l = cnt_l - LW'(1);
      end

      start_state  = ST_ENDS;
      start_status = STS_OK;
      start_ipos   = '0;
      start_idx    = '0;
      start_rem    = '0;
      go_up        = 1'b0;
      go_down      = 1'b0;
      case (req_payload.operation)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) start_status = STS_FULL;
            else      go_up = 1'b1;
         end
         OP_INSERT: begin
            if (pos_l > cnt_l) start_status = STS_RANGE;
            else if (full)     start_status = STS_FULL;
            else               go_up = 1'b1;
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) start_status = STS_EMPTY;
            else       go_down = 1'b1;
         end
         OP_REMOVE: begin
            if (pos_l >= cnt_l) start_status = STS_RANGE;
            else                go_down = 1'b1;
         end
         OP_FIND: begin
            start_state = ST_FIND;
            start_rem   = count_ff;
         end
         OP_SORT: begin
            start_state = ST_SORT_LOAD;
         end
         OP_READ: begin
            if (pos_l >= cnt_l) begin
               start_status = STS_RANGE;
            end else begin
               start_state = ST_READ;
               start_ipos  = AW'(pos_l);
            end
         end
         default: ;
      endcase

      if (go_up) begin
         start_state = ST_SHIFT_UP;
         start_ipos  = AW'(up_l);
         start_rem   = CW'(cnt_l - up_l);
         start_idx   = AW'(cnt_l - LW'(1));
      end
      if (go_down) begin
         start_state = ST_SHIFT_DOWN;
         start_rem   = CW'(cnt_l - dn_l - LW'(1));
         start_idx   = AW'(dn_l + LW'(1));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = start_state;
         ST_SHIFT_UP,
         ST_SHIFT_DOWN: if (!issue && !pend_ff) state_in = ST_ENDS;
         ST_FIND:       if ((pend_ff && hit) || (!issue && !pend_ff)) state_in = ST_ENDS;
         ST_SORT_LOAD:  state_in = sort_more ? ST_SORT_HOLD : ST_ENDS;
         ST_SORT_HOLD:  state_in = ST_SORT_SCAN;
         ST_SORT_SCAN:  if (!issue && !pend_ff) state_in = ST_SORT_LOAD;
         ST_READ:       state_in = ST_READ_TAKE;
         ST_READ_TAKE:  state_in = ST_ENDS;
         ST_ENDS:       state_in = ST_DONE;
         ST_DONE:       if (res_ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in    = count_ff;
      pend_in     = pend_ff;
      val_in      = val_ff;
      cur_in      = cur_ff;
      ipos_in     = ipos_ff;
      idx_in      = idx_ff;
      wa_in       = wa_ff;
      i_in        = i_ff;
      rem_in      = rem_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      fpos_in     = fpos_ff;
      rval_in     = rval_ff;
      mem_we      = 1'b0;
      mem_waddr   = wa_ff;
      mem_wdata   = mem_rdata_a;
      mem_raddr_a = idx_ff;
      mem_raddr_b = AW'(count_ff - CW'(1));

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in    = take_in(req_payload.value);
               status_in = start_status;
               found_in  = 1'b0;
               fpos_in   = '0;
               rval_in   = '0;
               ipos_in   = start_ipos;
               idx_in    = start_idx;
               rem_in    = start_rem;
               pend_in   = 1'b0;
               i_in      = '0;
            end
         end
         ST_SHIFT_UP: begin
            // read entry k, write it to k+1 in the next cycle, walking down
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff - AW'(1);
               rem_in = rem_ff - CW'(1);
               wa_in  = idx_ff + AW'(1);
            end
            if (pend_ff) begin
               mem_we = 1'b1;
            end else if (!issue) begin
               mem_we    = 1'b1;
               mem_waddr = ipos_ff;
               mem_wdata = val_ff;
               count_in  = count_ff + CW'(1);
            end
         end
         ST_SHIFT_DOWN: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + AW'(1);
               rem_in = rem_ff - CW'(1);
               wa_in  = idx_ff - AW'(1);
            end
            if (pend_ff) begin
               mem_we = 1'b1;
            end else if (!issue) begin
               count_in = count_ff - CW'(1);
            end
         end
         ST_FIND: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + AW'(1);
               rem_in = rem_ff - CW'(1);
               wa_in  = idx_ff;
            end
            if (pend_ff && hit) begin
               found_in = 1'b1;
               fpos_in  = to7(LW'(wa_ff));
            end else if (!issue && !pend_ff) begin
               fpos_in = to7(cnt_l);
            end
         end
         ST_SORT_LOAD: begin
            mem_raddr_a = i_ff;
            pend_in     = 1'b0;
            if (sort_more) begin
               idx_in = i_ff + AW'(1);
               rem_in = count_ff - CW'(i_ff) - CW'(1);
            end
         end
         ST_SORT_HOLD: begin
            cur_in = mem_rdata_a;
         end
         ST_SORT_SCAN: begin
            // cur_ff stands for entry i until the pass ends
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + AW'(1);
               rem_in = rem_ff - CW'(1);
               wa_in  = idx_ff;
            end
            if (pend_ff) begin
               if (swap) begin
                  mem_we    = 1'b1;
                  mem_wdata = cur_ff;
                  cur_in    = mem_rdata_a;
               end
            end else if (!issue) begin
               mem_we    = 1'b1;
               mem_waddr = i_ff;
               mem_wdata = cur_ff;
               i_in      = i_ff + AW'(1);
            end
         end
         ST_READ: begin
            mem_raddr_a = ipos_ff;
         end
         ST_READ_TAKE: begin
            rval_in = give_out(mem_rdata_a);
         end
         ST_ENDS, ST_DONE: begin
            mem_raddr_a = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      res_payload.front_value    = empty ? '0 : give_out(mem_rdata_a);
      res_payload.back_value     = empty ? '0 : give_out(mem_rdata_b);
      res_payload.element_count  = to7(cnt_l);
      res_payload.is_empty       = empty;
      res_payload.found          = found_ff;
      res_payload.found_position = fpos_ff;
      res_payload.read_value     = rval_ff;
      res_payload.status         = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      cur_ff    <= cur_in;
      ipos_ff   <= ipos_in;
      idx_ff    <= idx_in;
      wa_ff     <= wa_in;
      i_ff      <= i_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fpos_ff   <= fpos_in;
      rval_ff   <= rval_in;
   end

endmodule

// ===== sv/bounded_sequence_store_sort_find_core.sv =====
// Push front, pop front, insert, remove, find and sort walk the single element memory, one
// entry per cycle; push back, pop back, read, rejected and unused-code items do not walk it.
// One item in work at a time; the next is taken the cycle after its result is loaded.
// Reset is synchronous: the count and control clear, memory contents are left as they are.
module bounded_sequence_store_sort_find_core import bssf_pkg::*; #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input logic          clock,
   input logic          reset,
   bssf_chan_if.sink    req_if,
   bssf_chan_if.source  rsp_if
);

   localparam int AW = $clog2(CAPACITY);

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr, mem_raddr_a, mem_raddr_b;
   logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

   logic            seq_ready, res_valid, slot_free, load;
   rsp_payload_type res_payload;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   bssf_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_WIDTH)
   ) u_mem (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .raddr_a (mem_raddr_a),
      .raddr_b (mem_raddr_b),
      .rdata_a (mem_rdata_a),
      .rdata_b (mem_rdata_b)
   );

   bssf_seq #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (seq_ready),
      .req_payload (req_if.payload),
      .res_valid   (res_valid),
      .res_ready   (slot_free),
      .res_payload (res_payload),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_raddr_a (mem_raddr_a),
      .mem_raddr_b (mem_raddr_b),
      .mem_rdata_a (mem_rdata_a),
      .mem_rdata_b (mem_rdata_b)
   );

   assign req_if.ready = seq_ready;

   // result register; the sequencer waits in its last state while it is full and stalled
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign load      = res_valid && slot_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_payload;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

endmodule

// ===== sv/bssf_checker.sv =====
// Port-level checker for the sequence store, bound to the top level.
`include "bounded_sequence_store_sort_find_core_macros.svh"

module bssf_checker import bssf_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   `BSSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "result dropped while stalled")
   `BSSF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready,
      "ready stayed high after an accepted item")
   `BSSF_ASSERT_IMPLY(a_empty_ends, clock, reset, rsp_valid && rsp_payload.is_empty,
      (rsp_payload.element_count == 7'd0) && (rsp_payload.front_value == 32'sd0)
         && (rsp_payload.back_value == 32'sd0),
      "empty store reports nonzero ends or count")
   `BSSF_ASSERT_IMPLY(a_error_clean, clock, reset, rsp_valid && (rsp_payload.status != STS_OK),
      !rsp_payload.found && (rsp_payload.read_value == 32'sd0),
      "failed item reports find or read data")

endmodule

bind bounded_sequence_store_sort_find_core bssf_checker u_bssf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

// ===== sim/bounded_sequence_store_sort_find_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sequence store: push, pop, insert, remove, find, sort, read.
module bounded_sequence_store_sort_find_core_test;
   import bssf_pkg::*;

   localparam int STORE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 600;
   localparam int PHASE_LEN    = 200;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [3:0] OP_LAST_CODE = 4'd15;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bssf_chan_if #(.payload_type(req_payload_type)) req_ch ();
   bssf_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   bounded_sequence_store_sort_find_core #(
      .CAPACITY    (STORE_DEPTH),
      .VALUE_WIDTH (32)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the store
   logic signed [31:0] shadow_store [STORE_DEPTH];
   int                 shadow_count = 0;

   req_payload_type pending_items [$];
   rsp_payload_type awaited_responses [$];

   int items_queued  = 0;
   int items_taken   = 0;
   int items_noted   = 0;
   int results_seen  = 0;
   int results_noted = 0;
   int error_count   = 0;
   int idle_cycles   = 0;
   int plan_count    = 0;
   int peak_fill     = 0;
   int status_tally [4] = '{0, 0, 0, 0};

   logic            send_valid;
   req_payload_type send_item;
   int              send_gap = 0;
   logic            take_ready;
   int              take_gap = 0;
   int              hold_left = 0;
   logic            progress;
   rsp_payload_type want_rsp;

   function automatic rsp_payload_type predict_response(req_payload_type rq);
      rsp_payload_type    r;
      int                 pos;
      int                 i;
      int                 j;
      logic signed [31:0] t;
      r   = '0;
      pos = int'(rq.position);
      case (rq.operation)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count >= STORE_DEPTH) begin
               r.status = STS_FULL;
            end else begin
               if (rq.operation == OP_PUSH_FRONT) begin
                  for (i = shadow_count; i > 0; i--) shadow_store[i] = shadow_store[i - 1];
                  shadow_store[0] = rq.value;
               end else begin
                  shadow_store[shadow_count] = rq.value;
               end
               shadow_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_count == 0) begin
               r.status = STS_EMPTY;
            end else begin
               if (rq.operation == OP_POP_FRONT) begin
                  for (i = 0; i + 1 < shadow_count; i++) shadow_store[i] = shadow_store[i + 1];
               end
               shadow_count--;
            end
         end
         OP_INSERT: begin
            if (pos > shadow_count) begin
               r.status = STS_RANGE;
            end else if (shadow_count >= STORE_DEPTH) begin
               r.status = STS_FULL;
            end else begin
               for (i = shadow_count; i > pos; i--) shadow_store[i] = shadow_store[i - 1];
               shadow_store[pos] = rq.value;
               shadow_count++;
            end
         end
         OP_REMOVE: begin
            if (pos >= shadow_count) begin
               r.status = STS_RANGE;
            end else begin
               for (i = pos; i + 1 < shadow_count; i++) shadow_store[i] = shadow_store[i + 1];
               shadow_count--;
            end
         end
         OP_FIND: begin
            i = 0;
            while (i < shadow_count && shadow_store[i] != rq.value) i++;
            r.found          = (i < shadow_count);
            r.found_position = 7'(i);
         end
         OP_SORT: begin
            for (i = 0; i < shadow_count; i++) begin
               for (j = i + 1; j < shadow_count; j++) begin
                  if (shadow_store[i] > shadow_store[j]) begin
                     t               = shadow_store[i];
                     shadow_store[i] = shadow_store[j];
                     shadow_store[j] = t;
                  end
               end
            end
         end
         OP_READ: begin
            if (pos >= shadow_count) r.status = STS_RANGE;
            else r.read_value = shadow_store[pos];
         end
         default: ;
      endcase
      if (shadow_count > 0) begin
         r.front_value = shadow_store[0];
         r.back_value  = shadow_store[shadow_count - 1];
      end
      r.element_count = 7'(shadow_count);
      r.is_empty      = (shadow_count == 0);
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // stretches of zero wait between stretches of random waits
   function automatic int draw_gap(int n);
      if ((n / 40) % 4 == 3) return 0;
      return $urandom_range(0, 6);
   endfunction

   // drive at the falling edge; the next item follows as soon as the gap runs out
   always @(negedge clock) begin
      send_valid = req_ch.valid;
      send_item  = req_ch.payload;
      if (reset) begin
         send_valid = 1'b0;
         send_gap   = 0;
      end else begin
         if (send_valid && items_taken != items_noted) begin
            items_noted = items_taken;
            send_valid  = 1'b0;
            send_gap    = draw_gap(items_taken);
         end
         if (!send_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_items.size() > 0) begin
               send_item = pending_items[0];
               pending_items.delete(0);
               send_valid = 1'b1;
            end
         end
      end
      req_ch.valid   <= send_valid;
      req_ch.payload <= send_item;
   end

   always @(negedge clock) begin
      take_ready = rsp_ch.ready;
      if (reset) begin
         take_ready = 1'b0;
         take_gap   = 0;
         hold_left  = 0;
      end else begin
         if (results_seen != results_noted) begin
            results_noted = results_seen;
            take_gap      = draw_gap(results_seen);
            // one long hold-off so the block backs up into its input
            if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            take_ready = 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            take_ready = 1'b0;
         end else begin
            take_ready = 1'b1;
         end
      end
      rsp_ch.ready <= take_ready;
   end

   always @(posedge clock) begin
      progress = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            progress = 1'b1;
            results_seen++;
            if (awaited_responses.size() == 0) begin
               $error("response item with no request outstanding");
               error_count++;
            end else begin
               want_rsp = awaited_responses[0];
               awaited_responses.delete(0);
               compare_field("front_value", want_rsp.front_value, rsp_ch.payload.front_value);
               compare_field("back_value", want_rsp.back_value, rsp_ch.payload.back_value);
               compare_field("element_count", want_rsp.element_count,
                             rsp_ch.payload.element_count);
               compare_field("is_empty", want_rsp.is_empty, rsp_ch.payload.is_empty);
               compare_field("found", want_rsp.found, rsp_ch.payload.found);
               compare_field("found_position", want_rsp.found_position,
                             rsp_ch.payload.found_position);
               compare_field("read_value", want_rsp.read_value, rsp_ch.payload.read_value);
               compare_field("status", want_rsp.status, rsp_ch.payload.status);
               status_tally[want_rsp.status]++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            progress = 1'b1;
            items_taken++;
            awaited_responses.insert(awaited_responses.size(),
                                     predict_response(req_ch.payload));
            if (shadow_count > peak_fill) peak_fill = shadow_count;
         end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // plan_count follows the fill level, which depends only on operations and positions
   task automatic add_item(logic [3:0] op, logic signed [31:0] val, int pos);
      req_payload_type it;
      it.operation = op;
      it.value     = val;
      it.position  = 7'(pos);
      pending_items.insert(pending_items.size(), it);
      items_queued++;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: if (plan_count < STORE_DEPTH) plan_count++;
         OP_POP_FRONT, OP_POP_BACK:   if (plan_count > 0) plan_count--;
         OP_INSERT: if (pos <= plan_count && plan_count < STORE_DEPTH) plan_count++;
         OP_REMOVE: if (pos < plan_count) plan_count--;
         default: ;
      endcase
   endtask

   task automatic drain_outstanding();
      while (items_taken != items_queued || awaited_responses.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return int'($urandom_range(0, 8)) - 4;
      if (roll < 52) return VALUE_MIN;
      if (roll < 59) return VALUE_MAX;
      if (roll < 62) return -1;
      return $urandom;
   endfunction

   // mostly in range, sometimes past it; top below zero means nothing is in range
   function automatic int pick_position(int top);
      if (top < 0) return $urandom_range(0, 127);
      if ($urandom_range(0, 99) < 15) return $urandom_range(top + 1, 127);
      return $urandom_range(0, top);
   endfunction

   function automatic logic [3:0] pick_operation(bit growing);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < (growing ? 20 : 5))  return OP_PUSH_FRONT;
      if (roll < (growing ? 40 : 10)) return OP_PUSH_BACK;
      if (roll < (growing ? 65 : 17)) return OP_INSERT;
      if (roll < (growing ? 69 : 40)) return OP_POP_FRONT;
      if (roll < (growing ? 73 : 63)) return OP_POP_BACK;
      if (roll < (growing ? 78 : 77)) return OP_REMOVE;
      if (roll < (growing ? 86 : 85)) return OP_FIND;
      if (roll < (growing ? 89 : 88)) return OP_SORT;
      if (roll < 97) return OP_READ;
      return 4'($urandom_range(int'(OP_READ) + 1, int'(OP_LAST_CODE)));
   endfunction

   initial begin
      logic [3:0] op;
      int         pos;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;

      // empty store corners
      add_item(OP_POP_FRONT, 0, 0);
      add_item(OP_POP_BACK, 0, 0);
      add_item(OP_REMOVE, 0, 0);
      add_item(OP_READ, 0, 0);
      add_item(OP_FIND, 0, 0);
      add_item(OP_SORT, 0, 0);
      add_item(OP_INSERT, 5, 1);                // past the end
      add_item(OP_INSERT, VALUE_MAX, 0);        // at the end of an empty store
      add_item(OP_PUSH_FRONT, VALUE_MIN, 0);
      add_item(OP_PUSH_BACK, -1, 0);
      add_item(OP_PUSH_BACK, 0, 127);
      add_item(OP_INSERT, 1, 4);                // at the end: appends
      add_item(OP_INSERT, 32'sh5555_5555, 2);
      add_item(OP_READ, 0, 127);
      add_item(OP_READ, 0, 0);
      add_item(OP_FIND, 1, 0);
      add_item(OP_FIND, 12345, 0);
      add_item(OP_SORT, 0, 0);
      add_item(OP_READ, 0, 5);
      add_item(OP_FIND, -1, 0);
      add_item(OP_REMOVE, 0, 6);                // position equal to count
      add_item(OP_REMOVE, 0, 0);
      add_item(OP_POP_FRONT, 0, 0);
      add_item(OP_POP_BACK, 0, 0);
      add_item(OP_LAST_CODE, 32'shAAAA_AAAA, 42);
      add_item(OP_READ + 4'd1, VALUE_MIN, 85);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      drain_outstanding();

      // alternate filling and draining phases so full and empty both get hit
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_outstanding();
         op = pick_operation((n / PHASE_LEN) % 2 == 0);
         case (op)
            OP_INSERT:          pos = pick_position(plan_count);
            OP_REMOVE, OP_READ: pos = pick_position(plan_count - 1);
            default:            pos = $urandom_range(0, 127);
         endcase
         add_item(op, pick_value(), pos);
      end

      drain_outstanding();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests, %0d responses checked, peak fill %0d of %0d.",
               items_taken, results_seen, peak_fill, STORE_DEPTH);
      $display("Statuses seen: ok %0d, empty %0d, full %0d, out of range %0d.",
               status_tally[STS_OK], status_tally[STS_EMPTY], status_tally[STS_FULL],
               status_tally[STS_RANGE]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
